### hdl/bit_vector_set_engine_defines.svh
// ----------------------------------------------------------------------------
// Bit vector set engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_SET_ENGINE_DEFINES_SVH
`define BIT_VECTOR_SET_ENGINE_DEFINES_SVH

// Same-cycle implication
`define BVS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bvs_pkg.sv
// ----------------------------------------------------------------------------
// Bit vector set engine package
// Field widths, op codes, word-level command format and shared constants.
// ----------------------------------------------------------------------------
package bvs_pkg;

  // Fixed widths of the channel fields
  localparam int OP_W      = 4;
  localparam int ELEM_W    = 10;
  localparam int WIDX_W    = 5;
  localparam int SIZE_W    = 11;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;   // bit position inside a word
  localparam int WCNT_W    = 7;   // word count/position, up to 64 words of a 2047 size
  localparam int HASH_W    = 32;

  localparam int MAX_BITS_DEF = 1024;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [SIZE_W-1:0]    SIZE_RESET = 11'd1024;
  localparam logic [HASH_W-1:0]    HASH_MULT  = 32'd77;
  localparam logic [WORD_BITS-1:0] WORD_ONES  = 32'hffff_ffff;

  // Op codes of the input word
  localparam logic [OP_W-1:0] OP_INSERT      = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE      = 4'd1;
  localparam logic [OP_W-1:0] OP_MEMBER      = 4'd2;
  localparam logic [OP_W-1:0] OP_FILL        = 4'd3;
  localparam logic [OP_W-1:0] OP_EMPTY       = 4'd4;
  localparam logic [OP_W-1:0] OP_EMPTY_RANGE = 4'd5;
  localparam logic [OP_W-1:0] OP_FULL_RANGE  = 4'd6;
  localparam logic [OP_W-1:0] OP_HASH        = 4'd7;
  localparam logic [OP_W-1:0] OP_LOAD_WORD   = 4'd8;
  localparam logic [OP_W-1:0] OP_AND_WORD    = 4'd9;
  localparam logic [OP_W-1:0] OP_EQ_WORD     = 4'd10;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ELEM_W-1:0]    element;
    logic [ELEM_W-1:0]    range_last;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic              flag;
    logic [HASH_W-1:0] hash_value;
    logic              status;
  } out_item_t;

  // Work kinds handed from the front end to the back end
  typedef enum logic [3:0] {
    CMD_SET,
    CMD_CLR,
    CMD_TEST,
    CMD_FILL,
    CMD_EMPTY,
    CMD_RNG_EMPTY,
    CMD_RNG_FULL,
    CMD_HASH,
    CMD_LOAD,
    CMD_AND,
    CMD_EQ,
    CMD_DONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [WCNT_W-1:0]    first_w;
    logic [WCNT_W-1:0]    last_w;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] value;   // other-set word, or hash seed
    logic                 flag;    // initial / final flag
    logic                 status;
  } cmd_t;

endpackage

### hdl/bit_vector_set_engine.sv
// ----------------------------------------------------------------------------
// Bit vector set engine
// A set of up to MAX_BITS elements kept as 32-bit words, with element,
// range, fill, hash and word operations.
// ----------------------------------------------------------------------------
// After reset the engine clears its word store, one word per cycle, with
// in_ready low. In the back end each item then visits stored words through
// the single store port: one for insert, remove, member and the word ops,
// the used words (ceil(size / 32), 32 at the default size) for fill, empty
// and hash, the spanned words for a range check, and none for items
// answered at once (out-of-range, empty range, unknown op). A two-entry
// command queue lets the next items be accepted while one is being worked,
// and the result sits in an output register.
// ----------------------------------------------------------------------------
module bit_vector_set_engine import bvs_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  logic init_done;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd_in, q_head;

  bvs_front #(.MAX_BITS(MAX_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .init_done  (init_done),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd_in)
  );

  bvs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd_in),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  bvs_back #(.MAX_BITS(MAX_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .init_done(init_done),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### hdl/bvs_queue.sv
// ----------------------------------------------------------------------------
// Bit vector set engine command queue
// Small FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module bvs_queue import bvs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == DEPTH_CNT);
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hdl/bvs_front.sv
// ----------------------------------------------------------------------------
// Bit vector set engine front end
// Holds the set size, accepts input words and turns each into a word-level
// command: range of words to visit, bit bounds, or an immediate answer.
// ----------------------------------------------------------------------------
module bvs_front import bvs_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  input  logic              init_done,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [SIZE_W-1:0]   set_size_r;
  logic [SIZE_W-1:0]   eff_size;
  logic [SIZE_W:0]     nw_sum;
  logic [WCNT_W-1:0]   num_words;
  logic                elem_bad;
  logic                widx_bad;
  logic [WCNT_W-1:0]   elem_word;
  logic [WCNT_W-1:0]   last_word;
  cmd_t                cmd;

  // Hold the set size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      set_size_r <= cfg_wr_data;
    end
  end

  // Saturate the size and count the words in use
  always_comb begin
    if (32'(set_size_r) > MAX_BITS) begin
      eff_size = SIZE_W'(MAX_BITS);
    end else begin
      eff_size = set_size_r;
    end
    nw_sum    = {1'b0, eff_size} + (SIZE_W + 1)'(WORD_BITS - 1);
    num_words = WCNT_W'(nw_sum >> BIT_W);
  end

  assign elem_bad  = ({1'b0, in_data.element} >= eff_size);
  assign widx_bad  = (WCNT_W'(in_data.word_index) >= num_words);
  assign elem_word = WCNT_W'(in_data.element >> BIT_W);
  assign last_word = WCNT_W'(in_data.range_last >> BIT_W);

  // Classify the item
  always_comb begin
    cmd         = '0;
    cmd.kind    = CMD_DONE;
    cmd.lo_bit  = in_data.element[BIT_W-1:0];
    cmd.hi_bit  = in_data.range_last[BIT_W-1:0];
    cmd.value   = in_data.word_value;
    case (in_data.op)
      OP_INSERT, OP_REMOVE, OP_MEMBER: begin
        cmd.first_w = elem_word;
        cmd.last_w  = elem_word;
        if (elem_bad) begin
          cmd.status = 1'b1;
        end else if (in_data.op == OP_INSERT) begin
          cmd.kind = CMD_SET;
        end else if (in_data.op == OP_REMOVE) begin
          cmd.kind = CMD_CLR;
        end else begin
          cmd.kind = CMD_TEST;
        end
      end
      OP_FILL: begin
        cmd.last_w = num_words - 1'b1;
        if (num_words != '0) begin
          cmd.kind = CMD_FILL;
        end
      end
      OP_EMPTY: begin
        cmd.flag   = 1'b1;
        cmd.last_w = num_words - 1'b1;
        if (num_words != '0) begin
          cmd.kind = CMD_EMPTY;
        end
      end
      OP_EMPTY_RANGE, OP_FULL_RANGE: begin
        cmd.first_w = elem_word;
        cmd.last_w  = last_word;
        if (in_data.element > in_data.range_last) begin
          cmd.flag = 1'b1;
        end else if ({1'b0, in_data.range_last} >= eff_size) begin
          cmd.status = 1'b1;
        end else begin
          cmd.flag = 1'b1;
          cmd.kind = (in_data.op == OP_EMPTY_RANGE) ? CMD_RNG_EMPTY : CMD_RNG_FULL;
        end
      end
      OP_HASH: begin
        cmd.last_w = num_words - 1'b1;
        cmd.value  = WORD_BITS'(eff_size);
        if (num_words != '0) begin
          cmd.kind = CMD_HASH;
        end
      end
      OP_LOAD_WORD, OP_AND_WORD, OP_EQ_WORD: begin
        cmd.first_w = WCNT_W'(in_data.word_index);
        cmd.last_w  = WCNT_W'(in_data.word_index);
        if (widx_bad) begin
          cmd.status = 1'b1;
        end else if (in_data.op == OP_LOAD_WORD) begin
          cmd.kind = CMD_LOAD;
        end else if (in_data.op == OP_AND_WORD) begin
          cmd.kind = CMD_AND;
        end else begin
          cmd.kind = CMD_EQ;
        end
      end
      default: begin
        cmd.kind = CMD_DONE;
      end
    endcase
  end

  assign in_ready = init_done && !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_cmd    = cmd;

endmodule

### hdl/bvs_back.sv
// ----------------------------------------------------------------------------
// Bit vector set engine back end
// Owns the word store, clears it after reset, walks the words of each
// command one per cycle and registers the result word for the output.
// ----------------------------------------------------------------------------
module bvs_back import bvs_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      init_done,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(NUM_WORDS - 1);
  localparam logic [BIT_W-1:0] TOP_BIT   = BIT_W'(WORD_BITS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK, S_DONE} state_t;

  word_t             mem [NUM_WORDS];
  word_t             rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  word_t             mem_wd;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [WCNT_W-1:0] cur_r, cur_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              flag_r, flag_nxt;
  logic              status_r, status_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              at_end;
  logic [BIT_W-1:0]  lo_sel, hi_sel;
  word_t             rng_mask, bit_mask, and_word;

  // Word store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Bit bounds of the word under the walk
  always_comb begin
    at_end   = (cur_r == cmd_r.last_w);
    lo_sel   = (cur_r == cmd_r.first_w) ? cmd_r.lo_bit : '0;
    hi_sel   = at_end ? cmd_r.hi_bit : TOP_BIT;
    rng_mask = (WORD_ONES << lo_sel) & (WORD_ONES >> (TOP_BIT - hi_sel));
    bit_mask = WORD_BITS'(1) << cmd_r.lo_bit;
    and_word = rd_data_r & cmd_r.value;
  end

  // Sequence clearing, command walks and result hand-off
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    cmd_nxt       = cmd_r;
    flag_nxt      = flag_r;
    status_nxt    = status_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = AW'(cur_r);
    mem_wd        = '0;
    mem_ra        = AW'(cur_r);

    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_ra = AW'(q_cmd.first_w);
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          cur_nxt    = q_cmd.first_w;
          flag_nxt   = q_cmd.flag;
          status_nxt = q_cmd.status;
          hash_nxt   = (q_cmd.kind == CMD_HASH) ? q_cmd.value : '0;
          state_nxt  = (q_cmd.kind == CMD_DONE) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        mem_ra = at_end ? AW'(cur_r) : AW'(cur_r + 1'b1);
        case (cmd_r.kind)
          CMD_SET: begin
            flag_nxt = ((rd_data_r & bit_mask) == '0);
            mem_we   = 1'b1;
            mem_wd   = rd_data_r | bit_mask;
          end
          CMD_CLR: begin
            flag_nxt = ((rd_data_r & bit_mask) != '0);
            mem_we   = 1'b1;
            mem_wd   = rd_data_r & ~bit_mask;
          end
          CMD_TEST: begin
            flag_nxt = ((rd_data_r & bit_mask) != '0);
          end
          CMD_FILL: begin
            mem_we = 1'b1;
            mem_wd = WORD_ONES;
          end
          CMD_EMPTY: begin
            if (rd_data_r != '0) begin
              flag_nxt = 1'b0;
            end
          end
          CMD_RNG_EMPTY: begin
            if ((rd_data_r & rng_mask) != '0) begin
              flag_nxt = 1'b0;
            end
          end
          CMD_RNG_FULL: begin
            if ((~rd_data_r & rng_mask) != '0) begin
              flag_nxt = 1'b0;
            end
          end
          CMD_HASH: begin
            hash_nxt = hash_r * HASH_MULT + rd_data_r;
          end
          CMD_LOAD: begin
            flag_nxt = (rd_data_r != cmd_r.value);
            mem_we   = 1'b1;
            mem_wd   = cmd_r.value;
          end
          CMD_AND: begin
            flag_nxt = (and_word != rd_data_r);
            mem_we   = 1'b1;
            mem_wd   = and_word;
          end
          CMD_EQ: begin
            flag_nxt = (rd_data_r == cmd_r.value);
          end
          default: begin
            flag_nxt = flag_r;
          end
        endcase
        if (at_end) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.flag       = flag_r;
          out_data_nxt.hash_value = hash_r;
          out_data_nxt.status     = status_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    cmd_r      <= cmd_nxt;
    flag_r     <= flag_nxt;
    status_r   <= status_nxt;
    hash_r     <= hash_nxt;
    out_data_r <= out_data_nxt;
  end

  assign init_done = (state_r != S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/bvs_checker.sv
// ----------------------------------------------------------------------------
// Bit vector set engine port checker
// Watches the top-level ports for clearing, result and ordering slips.
// ----------------------------------------------------------------------------
`include "bit_vector_set_engine_defines.svh"

module bvs_checker import bvs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic [2:0] pending_r;
  logic       in_acc, out_acc;
  logic       out_stall, out_answer, out_clean;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Classify the result word on the output port
  assign out_stall  = out_valid && !out_ready;
  assign out_answer = out_valid && (out_data.flag || out_data.status);
  assign out_clean  = (out_data.hash_value == '0) && !(out_data.flag && out_data.status);

  // Track items accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  `BVS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result word moved")
  `BVS_ASSERT_IMPL(a_clear_blocks, !$past(rst_n), !in_ready, "input taken during store clear")
  `BVS_ASSERT_IMPL(a_result_shape, out_answer, out_clean, "inconsistent result fields")
  `BVS_ASSERT_IMPL(a_no_spurious, out_valid, pending_r != '0, "result with no item outstanding")

endmodule

bind bit_vector_set_engine bvs_checker u_bvs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### test/tb_bit_vector_set_engine.sv
// ----------------------------------------------------------------------------
// Bit vector set engine testbench
// Drives op words through the valid/ready input channel, predicts each
// result word from a local copy of the word store and the set size, and
// checks every result field by field. Directed cases cover element, range,
// fill, hash, word and unknown ops across the size extremes; random traffic
// follows under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_bit_vector_set_engine;
  import bvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WORDS      = MAX_BITS_DEF / WORD_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 400;

  // Op codes the engine ignores
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd11;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  // Predictor state
  word_t             set_words [NUM_WORDS];
  logic [SIZE_W-1:0] set_size_q = SIZE_RESET;
  out_item_t         pending_results[$];

  int error_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  bit_vector_set_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned eff_size();
    return (set_size_q > MAX_BITS_DEF) ? MAX_BITS_DEF : set_size_q;
  endfunction

  // Apply one op word to the local store and return the result word it gives
  function automatic out_item_t apply_set_op(in_item_t it);
    out_item_t   r;
    int unsigned size, nw, w, e;
    logic        present;
    word_t       h, merged;
    r = '0;
    size = eff_size();
    nw = (size + WORD_BITS - 1) / WORD_BITS;
    case (it.op)
      OP_INSERT, OP_REMOVE, OP_MEMBER: begin
        if (it.element >= size) begin
          r.status = 1'b1;
        end else begin
          w = it.element / WORD_BITS;
          present = set_words[w][it.element % WORD_BITS];
          if (it.op == OP_INSERT) begin
            r.flag = !present;
            set_words[w][it.element % WORD_BITS] = 1'b1;
          end else if (it.op == OP_REMOVE) begin
            r.flag = present;
            set_words[w][it.element % WORD_BITS] = 1'b0;
          end else begin
            r.flag = present;
          end
        end
      end
      OP_FILL: begin
        for (w = 0; w < nw; w++) set_words[w] = WORD_ONES;
      end
      OP_EMPTY: begin
        r.flag = 1'b1;
        for (w = 0; w < nw; w++) if (set_words[w] != '0) r.flag = 1'b0;
      end
      OP_EMPTY_RANGE, OP_FULL_RANGE: begin
        if (it.element > it.range_last) begin
          r.flag = 1'b1;
        end else if (it.range_last >= size) begin
          r.status = 1'b1;
        end else begin
          r.flag = 1'b1;
          for (e = it.element; e <= it.range_last; e++) begin
            present = set_words[e / WORD_BITS][e % WORD_BITS];
            if ((it.op == OP_EMPTY_RANGE) == present) r.flag = 1'b0;
          end
        end
      end
      OP_HASH: begin
        if (nw != 0) begin
          h = size;
          for (w = 0; w < nw; w++) h = h * HASH_MULT + set_words[w];
          r.hash_value = h;
        end
      end
      OP_LOAD_WORD, OP_AND_WORD, OP_EQ_WORD: begin
        if (it.word_index >= nw) begin
          r.status = 1'b1;
        end else if (it.op == OP_LOAD_WORD) begin
          r.flag = (set_words[it.word_index] != it.word_value);
          set_words[it.word_index] = it.word_value;
        end else if (it.op == OP_AND_WORD) begin
          merged = set_words[it.word_index] & it.word_value;
          r.flag = (merged != set_words[it.word_index]);
          set_words[it.word_index] = merged;
        end else begin
          r.flag = (set_words[it.word_index] == it.word_value);
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [ELEM_W-1:0] elem,
                                         logic [ELEM_W-1:0] last,
                                         logic [WIDX_W-1:0] widx, word_t wval);
    in_item_t it;
    it.op = op;
    it.element = elem;
    it.range_last = last;
    it.word_index = widx;
    it.word_value = wval;
    return it;
  endfunction

  // Mostly in-range, well-formed words with a share of out-of-range noise
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned size, nw, pick, span, lim;
    size = eff_size();
    nw = (size + WORD_BITS - 1) / WORD_BITS;
    it.element    = $urandom;
    it.range_last = $urandom;
    it.word_index = $urandom;
    it.word_value = $urandom;
    pick = $urandom_range(99);
    if (pick < 20)      it.op = OP_INSERT;
    else if (pick < 35) it.op = OP_REMOVE;
    else if (pick < 48) it.op = OP_MEMBER;
    else if (pick < 51) it.op = OP_FILL;
    else if (pick < 56) it.op = OP_EMPTY;
    else if (pick < 64) it.op = OP_EMPTY_RANGE;
    else if (pick < 72) it.op = OP_FULL_RANGE;
    else if (pick < 77) it.op = OP_HASH;
    else if (pick < 84) it.op = OP_LOAD_WORD;
    else if (pick < 91) it.op = OP_AND_WORD;
    else if (pick < 98) it.op = OP_EQ_WORD;
    else                it.op = $urandom_range(OP_UNUSED_HI, OP_UNUSED_LO);
    if (size > 0 && $urandom_range(9) != 0) it.element = $urandom_range(size - 1);
    // Short ranges inside the size so both range answers show up
    if (size > 0 && $urandom_range(9) < 8) begin
      span = $urandom_range(40);
      lim = it.element + span;
      it.range_last = (lim >= size) ? size - 1 : lim;
    end
    if (nw > 0 && $urandom_range(9) != 0) it.word_index = $urandom_range(nw - 1);
    if (it.word_index < NUM_WORDS) begin
      case ($urandom_range(4))
        0:       it.word_value = set_words[it.word_index];
        1:       it.word_value = set_words[it.word_index] ^ (word_t'(1) << $urandom_range(31));
        2:       it.word_value = $urandom_range(1) ? WORD_ONES : '0;
        default: it.word_value = $urandom;
      endcase
    end
    return it;
  endfunction

  // Offer one word after a random idle stretch, predict it once accepted
  task automatic send_word(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_set_op(it));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_set_size(input logic [SIZE_W-1:0] size);
    wait_results_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    set_size_q = size;
  endtask

  task automatic test_reset_state();
    send_word(make_item(OP_EMPTY, '0, '0, '0, '0));
    send_word(make_item(OP_HASH, '0, '0, '0, '0));
  endtask

  task automatic test_element_ops();
    write_set_size(SIZE_RESET);
    send_word(make_item(OP_INSERT, 10'd0, '0, '0, '0));
    send_word(make_item(OP_INSERT, 10'd0, '0, '0, '0));
    send_word(make_item(OP_INSERT, 10'd1023, '0, '0, '0));
    send_word(make_item(OP_REMOVE, 10'd1023, '0, '0, '0));
    send_word(make_item(OP_REMOVE, 10'd1023, '0, '0, '0));
    send_word(make_item(OP_MEMBER, 10'd0, '0, '0, '0));
  endtask

  task automatic test_range_ops();
    send_word(make_item(OP_FULL_RANGE, 10'd0, 10'd0, '0, '0));
    send_word(make_item(OP_EMPTY_RANGE, 10'd1, 10'd1023, '0, '0));
    // first element past the last one: empty range
    send_word(make_item(OP_FULL_RANGE, 10'd10, 10'd5, '0, '0));
  endtask

  task automatic test_fill_and_hash();
    send_word(make_item(OP_FILL, '0, '0, '0, '0));
    send_word(make_item(OP_FULL_RANGE, 10'd0, 10'd1023, '0, '0));
    send_word(make_item(OP_HASH, '0, '0, '0, '0));
  endtask

  task automatic test_word_ops();
    send_word(make_item(OP_AND_WORD, '0, '0, 5'd31, 32'ha5a5_a5a5));
    send_word(make_item(OP_EQ_WORD, '0, '0, 5'd31, 32'ha5a5_a5a5));
    send_word(make_item(OP_LOAD_WORD, '0, '0, 5'd0, '0));
  endtask

  task automatic test_unknown_op();
    send_word(make_item(OP_UNUSED_HI, '1, '1, '1, '1));
  endtask

  // Size that ends inside a word: bits past the size still get filled
  task automatic test_short_size();
    write_set_size(11'd40);
    send_word(make_item(OP_INSERT, 10'd40, '0, '0, '0));
    send_word(make_item(OP_FULL_RANGE, 10'd0, 10'd40, '0, '0));
    send_word(make_item(OP_LOAD_WORD, '0, '0, 5'd2, '1));
    send_word(make_item(OP_FILL, '0, '0, '0, '0));
    send_word(make_item(OP_HASH, '0, '0, '0, '0));
  endtask

  task automatic test_zero_size();
    write_set_size(11'd0);
    send_word(make_item(OP_EMPTY, '0, '0, '0, '0));
    send_word(make_item(OP_MEMBER, 10'd0, '0, '0, '0));
    send_word(make_item(OP_HASH, '0, '0, '0, '0));
    send_word(make_item(OP_EQ_WORD, '0, '0, 5'd0, '0));
  endtask

  task automatic test_saturated_size();
    write_set_size('1);
    send_word(make_item(OP_MEMBER, 10'd1023, '0, '0, '0));
  endtask

  task automatic test_random_mix(input logic [SIZE_W-1:0] size, input int tx_pct,
                                 input int rx_pct, input int count);
    write_set_size(size);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_word(random_item());
  endtask

  // Receiver holds off long enough for the engine to stall its input
  task automatic test_input_backpressure();
    write_set_size(SIZE_RESET);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = LONG_HOLD;
    repeat (24) send_word(random_item());
  endtask

  // Sender stops until the engine is empty, then resumes
  task automatic test_sender_pause();
    write_set_size($urandom_range(2047, 1025));
    tx_idle_pct  = 29;
    rx_stall_pct = 29;
    repeat (15) send_word(random_item());
    wait_results_drained();
    repeat (15) send_word(random_item());
  endtask

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.flag !== want.flag) begin
          $error("flag: expected %0b, got %0b", want.flag, out_data.flag);
          error_count++;
        end
        if (out_data.hash_value !== want.hash_value) begin
          $error("hash_value: expected %08h, got %08h", want.hash_value, out_data.hash_value);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bit_vector_set_engine: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (set_words[i]) set_words[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_element_ops();
    test_range_ops();
    test_fill_and_hash();
    test_word_ops();
    test_unknown_op();
    test_short_size();
    test_zero_size();
    test_saturated_size();

    test_random_mix(SIZE_RESET, 0, 0, 120);
    test_random_mix(11'd33, 48, 0, 80);
    test_random_mix(11'd1, 0, 48, 50);
    test_random_mix($urandom_range(1023, 2), 29, 29, 80);
    test_random_mix(11'd0, 48, 48, 20);
    test_random_mix('1, 29, 29, 80);
    test_random_mix(11'd32, 0, 0, 40);
    test_input_backpressure();
    test_sender_pause();

    // Let the last results out, then settle
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_bit_vector_set_engine: PASS");
    end else begin
      $display("tb_bit_vector_set_engine: FAIL");
    end
    $finish;
  end

endmodule
